// File: src/b32d_pkg.sv
// Package with the transaction types, alphabet table and symbol lookup for the Base32 decoder.
`timescale 1ns / 1ps

package b32d_pkg;

    localparam int unsigned ALPHABET_SIZE = 32;
    localparam int unsigned SYM_W = 5;
    localparam int unsigned BUF_W = 7;
    localparam int unsigned CNT_W = 3;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned QCNT_W = 2;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [7:0] PAD_CHAR_RESET = 8'd83;
    localparam logic [ADDR_W-1:0] ADDR_PAD_CHAR = 3'd0;

    localparam logic [7:0] ALPHABET [ALPHABET_SIZE] = '{
        8'h59, 8'h39, 8'h4E, 8'h44, 8'h36, 8'h55, 8'h30, 8'h52,
        8'h58, 8'h43, 8'h50, 8'h49, 8'h4F, 8'h48, 8'h51, 8'h4C,
        8'h34, 8'h31, 8'h38, 8'h47, 8'h37, 8'h4B, 8'h41, 8'h56,
        8'h4A, 8'h33, 8'h46, 8'h57, 8'h35, 8'h42, 8'h5A, 8'h54
    };

    typedef struct packed {
        logic [7:0] symbol_char;
        logic       last_symbol;
    } b32d_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } b32d_out_t;

    typedef struct packed {
        logic [SYM_W-1:0] value;
        logic             last;
    } b32d_sym_t;

    function automatic logic [SYM_W-1:0] symbol_value(
        input logic [7:0] c,
        input logic [7:0] pad
    );
        logic [SYM_W-1:0] v;
        v = '0;
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            if (ALPHABET[i] == c)
            begin
                v = SYM_W'(i);
            end
        end
        if (c == pad)
        begin
            v = '0;
        end
        return v;
    endfunction

endpackage

// File: src/b32d_front.sv
// Front stage that accepts characters and registers their 5-bit symbol values.
`timescale 1ns / 1ps

module b32d_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          pad_char,
    input  logic                symbol_valid,
    output logic                symbol_ready,
    input  b32d_pkg::b32d_in_t  symbol,
    output logic                push_valid,
    input  logic                push_ready,
    output b32d_pkg::b32d_sym_t push_data
);

    logic                valid_reg;
    logic                valid_next;
    b32d_pkg::b32d_sym_t data_reg;
    logic                take;

    assign symbol_ready = !valid_reg || push_ready;
    assign take = symbol_valid && symbol_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.value <= b32d_pkg::symbol_value(symbol.symbol_char, pad_char);
            data_reg.last  <= symbol.last_symbol;
        end
    end

    assign push_valid = valid_reg;
    assign push_data  = data_reg;

endmodule

// File: src/b32d_queue.sv
// Two-entry queue that decouples the front stage from the bit packer.
`timescale 1ns / 1ps

module b32d_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  b32d_pkg::b32d_sym_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output b32d_pkg::b32d_sym_t pop_data
);

    b32d_pkg::b32d_sym_t                     entry_reg [b32d_pkg::QUEUE_DEPTH];
    logic [b32d_pkg::QPTR_W-1:0]             wr_ptr_reg;
    logic [b32d_pkg::QPTR_W-1:0]             wr_ptr_next;
    logic [b32d_pkg::QPTR_W-1:0]             rd_ptr_reg;
    logic [b32d_pkg::QPTR_W-1:0]             rd_ptr_next;
    logic [b32d_pkg::QCNT_W-1:0]             count_reg;
    logic [b32d_pkg::QCNT_W-1:0]             count_next;
    logic                                    push;
    logic                                    pop;

    assign push_ready = (count_reg != b32d_pkg::QCNT_W'(b32d_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/b32d_back.sv
// Bit packer that assembles symbol values into bytes and holds the output register.
`timescale 1ns / 1ps

module b32d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  b32d_pkg::b32d_sym_t pop_data,
    output logic                result_valid,
    input  logic                result_ready,
    output b32d_pkg::b32d_out_t result
);

    logic [b32d_pkg::BUF_W-1:0] buf_reg;
    logic [b32d_pkg::BUF_W-1:0] buf_next;
    logic [b32d_pkg::CNT_W-1:0] cnt_reg;
    logic [b32d_pkg::CNT_W-1:0] cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    b32d_pkg::b32d_out_t        out_reg;
    b32d_pkg::b32d_out_t        out_next;
    logic                       pop;
    logic [11:0]                acc;
    logic [3:0]                 sum;
    logic [2:0]                 rest;
    logic [11:0]                shifted;
    logic [b32d_pkg::BUF_W-1:0] mask;
    logic                       have_byte;
    logic                       emit;

    assign pop_ready = !out_valid_reg || result_ready;
    assign pop = pop_valid && pop_ready;

    always_comb
    begin
        acc       = {buf_reg, pop_data.value};
        sum       = {1'b0, cnt_reg} + 4'd5;
        have_byte = sum[3];
        rest      = sum[2:0];
        shifted   = acc >> rest;
        mask      = b32d_pkg::BUF_W'((8'd1 << rest) - 8'd1);
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        emit      = have_byte || pop_data.last;
        out_next  = out_reg;
        if (pop)
        begin
            if (have_byte)
            begin
                buf_next = acc[b32d_pkg::BUF_W-1:0] & mask;
            end
            else
            begin
                buf_next = acc[b32d_pkg::BUF_W-1:0];
            end
            cnt_next = rest;
            if (pop_data.last)
            begin
                buf_next = '0;
                cnt_next = '0;
            end
            out_next.data_byte      = have_byte ? shifted[7:0] : 8'd0;
            out_next.byte_valid     = have_byte;
            out_next.end_of_message = pop_data.last;
        end
        out_valid_next = out_valid_reg;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: src/base32_custom_alphabet_decoder.sv
// Top level of the streaming Base32 decoder with a custom alphabet and configurable pad character.
// A character passes the front register and a queue entry before it can load the output register.
// Throughput: one character per cycle while result_ready stays high, set by the bit packer.
// A two-entry queue lets the front stage keep accepting during an output stall until it fills.
// Reset: rst_n is asynchronous and active low; it clears the bit buffer and all valid flags.
// After reset the pad character is 'S'.
`timescale 1ns / 1ps

module base32_custom_alphabet_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [b32d_pkg::ADDR_W-1:0]       paddr,
    input  logic [b32d_pkg::DATA_W-1:0]       pwdata,
    output logic [b32d_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              symbol_valid,
    output logic                              symbol_ready,
    input  b32d_pkg::b32d_in_t                symbol,
    output logic                              result_valid,
    input  logic                              result_ready,
    output b32d_pkg::b32d_out_t               result
);

    logic [7:0]          pad_char_reg;
    logic [7:0]          pad_char_next;
    logic                pad_sel;
    logic                push_valid;
    logic                push_ready;
    b32d_pkg::b32d_sym_t push_data;
    logic                pop_valid;
    logic                pop_ready;
    b32d_pkg::b32d_sym_t pop_data;

    assign pready  = 1'b1;
    assign pad_sel = (paddr[b32d_pkg::ADDR_W-1:2] == b32d_pkg::ADDR_PAD_CHAR[b32d_pkg::ADDR_W-1:2]);

    always_comb
    begin
        pad_char_next = pad_char_reg;
        if (psel && penable && pwrite && pad_sel)
        begin
            pad_char_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_char_reg <= b32d_pkg::PAD_CHAR_RESET;
        end
        else
        begin
            pad_char_reg <= pad_char_next;
        end
    end

    assign prdata = pad_sel ? {24'd0, pad_char_reg} : '0;

    b32d_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pad_char     (pad_char_reg),
        .symbol_valid (symbol_valid),
        .symbol_ready (symbol_ready),
        .symbol       (symbol),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    b32d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b32d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
